FILE: sv/cwag_pkg.sv
// Shared constants, types and register codes for the centered window averager.
package cwag_pkg;

	localparam int MAX_HALF_WINDOW  = 7;
	localparam int SAMPLE_BITS      = 16;
	localparam int DEPTH            = 2 * MAX_HALF_WINDOW + 1;
	localparam int IDX_W            = $clog2(DEPTH);
	localparam int CNT_W            = $clog2(DEPTH + 1);
	localparam int HW_W             = $clog2(MAX_HALF_WINDOW + 1);
	localparam int HALF_WINDOW_BITS = 3;
	localparam int RNG_W            = $clog2(DEPTH + MAX_HALF_WINDOW + 1);
	localparam int SUM_W            = SAMPLE_BITS + CNT_W;
	localparam int MAG_W            = SAMPLE_BITS - 1 + CNT_W;
	localparam int NUM_W            = MAG_W + 1;
	localparam int DEN_W            = CNT_W + 1;
	localparam int STEP_W           = $clog2(NUM_W + 1);

	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_HALF_WINDOW   = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_ZERO_EXCLUDED = 1'd1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic shift;
		logic clear;
		logic load;
		logic scan;
	} cell_ctrl_t;

endpackage

FILE: sv/cwag_if.sv
// Stream channel interfaces for samples in and averages out.
interface cwag_in_if import cwag_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    sample_present;
	logic    row_end;

	modport source(output valid, sample, sample_present, row_end, input ready);
	modport sink(input valid, sample, sample_present, row_end, output ready);
endinterface

interface cwag_out_if import cwag_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t average;
	logic    average_present;
	logic    row_last;

	modport source(output valid, average, average_present, row_last, input ready);
	modport sink(input valid, average, average_present, row_last, output ready);
endinterface

FILE: sv/cwag_cell.sv
// One window cell: a stored sample plus a scan copy that drains toward cell zero.
module cwag_cell import cwag_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       in_range,
	input  sample_t    win_val_in,
	input  logic       win_cnt_in,
	input  sample_t    scan_val_in,
	input  logic       scan_cnt_in,
	output sample_t    win_val,
	output logic       win_cnt,
	output sample_t    scan_val,
	output logic       scan_cnt
);

	sample_t win_val_q;
	logic    win_cnt_q;
	sample_t scan_val_q;
	logic    scan_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cnt_q  <= 1'b0;
			scan_cnt_q <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				win_cnt_q <= 1'b0;
			end else if (ctrl.shift) begin
				win_cnt_q <= win_cnt_in;
			end
			if (ctrl.load) begin
				scan_cnt_q <= win_cnt_q && in_range;
			end else if (ctrl.scan) begin
				scan_cnt_q <= scan_cnt_in;
			end
		end
	end

	// values are only meaningful while the matching count bit is set
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			win_val_q <= win_val_in;
		end
		if (ctrl.load) begin
			scan_val_q <= win_val_q;
		end else if (ctrl.scan) begin
			scan_val_q <= scan_val_in;
		end
	end

	assign win_val  = win_val_q;
	assign win_cnt  = win_cnt_q;
	assign scan_val = scan_cnt_q ? scan_val_q : '0;
	assign scan_cnt = scan_cnt_q;

endmodule

FILE: sv/cwag_div.sv
// Restoring divider, one quotient bit per cycle.
module cwag_div import cwag_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] steps_q;
	logic              done_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				steps_q <= STEP_W'(NUM_W);
			end else if (steps_q != '0) begin
				steps_q <= steps_q - 1'b1;
				done_q  <= (steps_q == STEP_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (steps_q != '0) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

FILE: sv/centered_window_average_with_gaps_core.sv
// An item that gives no result leaves the block idle, ready for the next item;
// a row end gives up to half_window+1 results, one per window center.
// Per result: load, scan the chain, divide (start, steps, done) if any counts, write the output.
// The next item is taken once the last result of the previous item is in the output register.
// Reset: asynchronous active-low arst_n empties the window, half_window = 1, zero_excluded = 0.
module centered_window_average_with_gaps_core import cwag_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	cwag_in_if.sink           in_ch,
	cwag_out_if.source        out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOAD   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DSTART = 3'd3;
	localparam logic [2:0] ST_DWAIT  = 3'd4;
	localparam logic [2:0] ST_PUT    = 3'd5;

	localparam logic [NUM_W-1:0] MAXV = NUM_W'((1 << (SAMPLE_BITS - 1)) - 1);

	// Configuration registers
	logic [HALF_WINDOW_BITS-1:0] half_window_q;
	logic                        zero_excluded_q;
	logic [REG_IDX_W-1:0]        reg_idx;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_window_q   <= HALF_WINDOW_BITS'(1);
			zero_excluded_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_HALF_WINDOW:   half_window_q   <= pwdata[HALF_WINDOW_BITS-1:0];
				REG_ZERO_EXCLUDED: zero_excluded_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HALF_WINDOW:   prdata = 32'(half_window_q);
			REG_ZERO_EXCLUDED: prdata = 32'(zero_excluded_q);
			default:           prdata = '0;
		endcase
	end

	// Effective half window, clipped to what the cell chain holds
	logic [HW_W-1:0] h_eff;
	assign h_eff = (int'(half_window_q) > MAX_HALF_WINDOW) ? HW_W'(MAX_HALF_WINDOW)
	                                                      : HW_W'(half_window_q);

	// Control state
	logic [2:0]       state_q;
	logic [CNT_W-1:0] seen_q;
	logic             row_end_q;
	logic [HW_W-1:0]  d_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic signed [SUM_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;

	logic    in_fire;
	logic    counts;
	sample_t new_val;
	logic [CNT_W-1:0] seen_inc;
	logic [RNG_W-1:0] seen_m1;
	logic [HW_W-1:0]  top_d;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;

	// A sample counts when present, and in zero-excluded mode when nonzero
	assign counts   = in_ch.sample_present && !(zero_excluded_q && (in_ch.sample == '0));
	assign new_val  = counts ? in_ch.sample : '0;
	assign seen_inc = (seen_q < CNT_W'(DEPTH)) ? seen_q + 1'b1 : seen_q;
	assign seen_m1  = RNG_W'(seen_inc) - 1'b1;
	assign top_d    = (seen_m1 < RNG_W'(h_eff)) ? seen_m1[HW_W-1:0] : h_eff;

	// Cell chain
	cell_ctrl_t       ctrl;
	sample_t          win_val_w  [DEPTH];
	logic [DEPTH-1:0] win_cnt_w;
	sample_t          scan_val_w [DEPTH];
	logic [DEPTH-1:0] scan_cnt_w;
	logic [DEPTH-1:0] in_range;

	// Cell i lies in the window of position d when d-h <= i <= d+h
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			in_range[i] = ((RNG_W'(i) + RNG_W'(h_eff)) >= RNG_W'(d_q)) &&
			              (RNG_W'(i) <= (RNG_W'(d_q) + RNG_W'(h_eff)));
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		sample_t wv_in;
		logic    wc_in;
		sample_t sv_in;
		logic    sc_in;

		if (g == 0) begin : g_head
			assign wv_in = new_val;
			assign wc_in = counts;
		end else begin : g_body
			assign wv_in = win_val_w[g-1];
			assign wc_in = win_cnt_w[g-1];
		end

		if (g == DEPTH - 1) begin : g_tail
			assign sv_in = '0;
			assign sc_in = 1'b0;
		end else begin : g_mid
			assign sv_in = scan_val_w[g+1];
			assign sc_in = scan_cnt_w[g+1];
		end

		cwag_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.in_range    (in_range[g]),
			.win_val_in  (wv_in),
			.win_cnt_in  (wc_in),
			.scan_val_in (sv_in),
			.scan_cnt_in (sc_in),
			.win_val     (win_val_w[g]),
			.win_cnt     (win_cnt_w[g]),
			.scan_val    (scan_val_w[g]),
			.scan_cnt    (scan_cnt_w[g])
		);
	end

	// Divider operands: (2|sum| + count) / (2 count) rounds half away from zero
	logic                    sum_neg;
	logic [SUM_W-1:0]        mag;
	logic [NUM_W-1:0]        numer;
	logic [DEN_W-1:0]        denom;
	logic                    div_start;
	logic                    div_done;
	logic [NUM_W-1:0]        quot;
	logic [CNT_W-1:0]        cnt_nxt;

	assign sum_neg = acc_q[SUM_W-1];
	assign mag     = sum_neg ? SUM_W'(-acc_q) : SUM_W'(acc_q);
	assign numer   = {mag[MAG_W-1:0], 1'b0} + NUM_W'(cnt_q);
	assign denom   = {cnt_q, 1'b0};
	assign cnt_nxt = cnt_q + CNT_W'(scan_cnt_w[0]);

	cwag_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (numer),
		.denom  (denom),
		.done   (div_done),
		.quot   (quot)
	);

	// Result formatting: negate, or saturate the positive side
	sample_t res_avg;
	logic    res_last;
	logic    put_fire;
	logic    out_valid_q;
	sample_t out_avg_q;
	logic    out_pres_q;
	logic    out_last_q;

	always_comb begin
		if (cnt_q == '0) begin
			res_avg = '0;
		end else if (sum_neg) begin
			res_avg = sample_t'(-quot[SAMPLE_BITS-1:0]);
		end else if (quot > MAXV) begin
			res_avg = sample_t'(MAXV[SAMPLE_BITS-1:0]);
		end else begin
			res_avg = sample_t'(quot[SAMPLE_BITS-1:0]);
		end
	end

	assign res_last = row_end_q && (d_q == '0);
	assign put_fire = (state_q == ST_PUT) && (!out_valid_q || out_ch.ready);

	always_comb begin
		ctrl       = '0;
		ctrl.shift = in_fire;
		ctrl.load  = (state_q == ST_LOAD);
		ctrl.scan  = (state_q == ST_SCAN);
		ctrl.clear = put_fire && res_last;
		div_start  = (state_q == ST_DSTART);
	end

	// Sequencer: load a window snapshot, drain it, divide if any sample counts, write the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			seen_q     <= '0;
			row_end_q  <= 1'b0;
			d_q        <= '0;
			scan_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						seen_q    <= seen_inc;
						row_end_q <= in_ch.row_end;
						if (in_ch.row_end) begin
							d_q     <= top_d;
							state_q <= ST_LOAD;
						end else if (RNG_W'(seen_inc) > RNG_W'(h_eff)) begin
							d_q     <= h_eff;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					scan_idx_q <= '0;
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + 1'b1;
					if (scan_idx_q == IDX_W'(DEPTH - 1)) begin
						state_q <= (cnt_nxt == '0) ? ST_PUT : ST_DSTART;
					end
				end
				ST_DSTART: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_done) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (put_fire) begin
						if (res_last) begin
							// flush done: drop the row and wait for the next one
							seen_q  <= '0;
							state_q <= ST_IDLE;
						end else if (row_end_q) begin
							d_q     <= d_q - 1'b1;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Accumulate the cell-zero output while the snapshot drains
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (state_q == ST_SCAN) begin
			acc_q <= acc_q + SUM_W'(scan_val_w[0]);
			cnt_q <= cnt_nxt;
		end
	end

	// Output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (put_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (put_fire) begin
			out_avg_q  <= res_avg;
			out_pres_q <= (cnt_q != '0);
			out_last_q <= res_last;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.average         = out_avg_q;
	assign out_ch.average_present = out_pres_q;
	assign out_ch.row_last        = out_last_q;

`ifndef SYNTHESIS
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= CNT_W'(DEPTH))
		else $error("samples seen exceeds window depth");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DWAIT))
		else $error("divider finished outside its wait state");

	a_center_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (d_q <= h_eff))
		else $error("window center beyond half window");

	a_row_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(put_fire && res_last) |=> (seen_q == '0) && (win_cnt_w == '0))
		else $error("window not cleared after last result of row");
`endif

endmodule

FILE: dv/cwag_checker.sv
// Checker for the centered window averager: predicts every average and compares it.
module cwag_checker import cwag_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	cwag_in_if                in_ch,
	cwag_out_if               out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output int                pending,
	output int                fail_count,
	output int                results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		sample_t average;
		logic    average_present;
		logic    row_last;
	} avg_result_t;

	avg_result_t                 expected_avgs[$];
	logic [HALF_WINDOW_BITS-1:0] half_window;
	logic                        zero_excluded;
	sample_t                     win_val [DEPTH];
	logic                        win_cnt [DEPTH];
	int                          row_fill;

	// Mean of the counted samples at window slots center-h .. center+h, newest at slot 0.
	function automatic avg_result_t window_mean(int center, int h, bit last);
		avg_result_t r;
		int          lo;
		int          hi;
		int          cnt;
		longint      sum;
		longint      mag;
		longint      q;
		longint      avg;
		lo  = (center > h) ? center - h : 0;
		hi  = (center + h > DEPTH - 1) ? DEPTH - 1 : center + h;
		sum = 0;
		cnt = 0;
		avg = 0;
		for (int i = lo; i <= hi; i++) begin
			if (win_cnt[i]) begin
				sum += longint'(win_val[i]);
				cnt++;
			end
		end
		if (cnt > 0) begin
			mag = (sum < 0) ? -sum : sum;
			q   = (2 * mag + cnt) / (2 * cnt);
			avg = (sum < 0) ? -q : q;
			if (avg > (longint'(1) <<< (SAMPLE_BITS - 1)) - 1)
				avg = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
			if (avg < -(longint'(1) <<< (SAMPLE_BITS - 1)))
				avg = -(longint'(1) <<< (SAMPLE_BITS - 1));
		end
		r.average         = sample_t'(avg);
		r.average_present = (cnt > 0);
		r.row_last        = last;
		return r;
	endfunction

	task automatic clear_window();
		for (int i = 0; i < DEPTH; i++) begin
			win_val[i] = '0;
			win_cnt[i] = 1'b0;
		end
		row_fill = 0;
	endtask

	task automatic predict_item(sample_t s, logic present, logic last);
		logic counts;
		int   h;
		int   top;
		counts = present && !(zero_excluded && s == 0);
		h = (half_window > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW : int'(half_window);
		for (int i = DEPTH - 1; i > 0; i--) begin
			win_val[i] = win_val[i-1];
			win_cnt[i] = win_cnt[i-1];
		end
		win_val[0] = counts ? s : '0;
		win_cnt[0] = counts;
		if (row_fill < DEPTH)
			row_fill++;
		if (!last) begin
			if (row_fill > h)
				expected_avgs.push_back(window_mean(h, h, 1'b0));
		end else begin
			// flush every pending position of the row, oldest first
			top = (row_fill - 1 < h) ? row_fill - 1 : h;
			for (int d = top; d >= 0; d--)
				expected_avgs.push_back(window_mean(d, h, d == 0));
			clear_window();
		end
	endtask

	task automatic check_result();
		avg_result_t e;
		if (expected_avgs.size() == 0) begin
			$display("%0t: unexpected result: average=%0d present=%0b last=%0b", $time,
				out_ch.average, out_ch.average_present, out_ch.row_last);
			fail_count++;
			return;
		end
		e = expected_avgs.pop_front();
		results_checked++;
		if (out_ch.average !== e.average) begin
			$display("%0t: average mismatch: expected %0d, actual %0d", $time,
				e.average, out_ch.average);
			fail_count++;
		end
		if (out_ch.average_present !== e.average_present) begin
			$display("%0t: average_present mismatch: expected %0b, actual %0b", $time,
				e.average_present, out_ch.average_present);
			fail_count++;
		end
		if (out_ch.row_last !== e.row_last) begin
			$display("%0t: row_last mismatch: expected %0b, actual %0b", $time,
				e.row_last, out_ch.row_last);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_window     = HALF_WINDOW_BITS'(1);
			zero_excluded   = 1'b0;
			clear_window();
			expected_avgs.delete();
			pending         = 0;
			fail_count      = 0;
			results_checked = 0;
		end else begin
			// results first, so one never pairs with an item taken at the same edge
			if (out_ch.valid && out_ch.ready)
				check_result();
			if (in_ch.valid && in_ch.ready)
				predict_item(in_ch.sample, in_ch.sample_present, in_ch.row_end);
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_HALF_WINDOW:   half_window   = pwdata[HALF_WINDOW_BITS-1:0];
					REG_ZERO_EXCLUDED: zero_excluded = pwdata[0];
					default: ;
				endcase
			end
			pending = expected_avgs.size();
		end
	end

endmodule

FILE: dv/centered_window_average_with_gaps_core_tb.sv
// Testbench top for the centered window averager: stimulus, idling and the verdict.
module centered_window_average_with_gaps_core_tb import cwag_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// drain time after the last expected result; covers an item that yields nothing
	localparam int SETTLE_CYCLES = 100;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 28;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [31:0]       pwdata  = '0;
	logic [31:0]       prdata;
	logic              pready;

	cwag_in_if  in_ch ();
	cwag_out_if out_ch ();

	int pending;
	int fail_count;
	int results_checked;
	int items_sent;
	int rows_sent;
	int settings_used;
	bit no_idle;

	centered_window_average_with_gaps_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	cwag_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ch           (in_ch),
		.out_ch          (out_ch),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pending         (pending),
		.fail_count      (fail_count),
		.results_checked (results_checked)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Gap length: mostly none, often a few cycles, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one item after a random gap; hold it until the block takes it.
	// Called and left at a falling edge.
	task automatic send_item(sample_t s, logic present, logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.sample         <= s;
		in_ch.sample_present <= present;
		in_ch.row_end        <= last;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
		if (last)
			rows_sent++;
		@(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Drop valid, wait out every expected average, then let the block go quiet.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure(int hw, int ze);
		drain();
		write_reg(REG_HALF_WINDOW, 32'(hw));
		write_reg(REG_ZERO_EXCLUDED, 32'(ze));
		settings_used++;
	endtask

	// Receiver: stall at random, sometimes for long stretches.
	initial begin
		int stall_left;
		stall_left   = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				if (!no_idle && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		int      hw;
		int      ze;
		int      left;
		int      row_left;
		int      r;
		sample_t s;
		in_ch.valid          = 1'b0;
		in_ch.sample         = '0;
		in_ch.sample_present = 1'b0;
		in_ch.row_end        = 1'b0;
		items_sent    = 0;
		rows_sent     = 0;
		settings_used = 1;
		no_idle       = 1'b0;
		row_left      = 0;

		// hold reset, then release it on a falling edge
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings (radius 1, zeros count): extremes, missing samples, ties.
		send_item(sample_t'(32767), 1'b1, 1'b0);
		send_item(sample_t'(-32768), 1'b1, 1'b0);
		send_item(sample_t'(0), 1'b1, 1'b0);
		send_item(sample_t'(5), 1'b0, 1'b0);
		send_item(sample_t'(1), 1'b1, 1'b0);
		send_item(sample_t'(2), 1'b1, 1'b1);       // tie rounds up, ends row
		send_item(sample_t'(1234), 1'b1, 1'b1);    // single-sample row
		send_item(sample_t'(100), 1'b0, 1'b0);
		send_item(sample_t'(0), 1'b0, 1'b1);       // row with nothing counted
		send_item(sample_t'(-1), 1'b1, 1'b0);
		send_item(sample_t'(-2), 1'b1, 1'b1);      // negative tie rounds away

		// Widest window with zeros excluded: a short row, then a row left open.
		configure(MAX_HALF_WINDOW, 1);
		send_item(sample_t'(0), 1'b1, 1'b0);
		send_item(sample_t'(7), 1'b1, 1'b0);
		send_item(sample_t'(0), 1'b1, 1'b0);
		send_item(sample_t'(-32768), 1'b1, 1'b1);
		for (int k = 0; k < 10; k++)
			send_item(sample_t'(k * 7000 - 32000), (k % 3) != 0, 1'b0);

		// Shrink the window to zero in the middle of that row, then finish it.
		configure(0, 0);
		send_item(sample_t'(0), 1'b1, 1'b0);
		send_item(sample_t'(32767), 1'b1, 1'b0);
		send_item(sample_t'(-3), 1'b1, 1'b1);

		// Random phases: both extreme radii first, then random settings.
		// Rows carry over phase boundaries, so some rows see a new radius.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			hw = (ph == 0) ? 0 : (ph == 1) ? MAX_HALF_WINDOW : $urandom_range(0, 7);
			ze = (ph < 2) ? ph : $urandom_range(0, 1);
			configure(hw, ze);
			no_idle = (ph == 3);
			left    = PHASE_ITEMS;
			while (left > 0) begin
				if (row_left == 0) begin
					r = $urandom_range(0, 99);
					row_left = (r < 70) ? $urandom_range(1, 12) :
						(r < 90) ? $urandom_range(13, 24) : $urandom_range(25, 40);
				end
				r = $urandom_range(0, 99);
				if (r < 10)
					s = '0;
				else if (r < 15)
					s = sample_t'(32767);
				else if (r < 20)
					s = sample_t'(-32768);
				else if (r < 25)
					s = sample_t'($urandom_range(0, 6) - 3);
				else
					s = sample_t'($urandom());
				send_item(s, $urandom_range(0, 99) < 75, row_left == 1);
				row_left--;
				left--;
			end
		end
		no_idle = 1'b0;

		drain();
		$display("Sent %0d items in %0d finished rows under %0d register settings;",
			items_sent, rows_sent, settings_used);
		$display("%0d averages compared against the window predictor.", results_checked);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

endmodule

FILE: filelist.f
sv/cwag_pkg.sv
sv/cwag_if.sv
sv/cwag_cell.sv
sv/cwag_div.sv
sv/centered_window_average_with_gaps_core.sv
dv/cwag_checker.sv
dv/centered_window_average_with_gaps_core_tb.sv
